// ===== rtl/core/sorted_priority_queue_top_defines.svh =====
// Assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// property holds at every edge outside reset
`define SPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

   localparam int DEPTH_DEF     = 8;
   localparam int RANK_BITS_DEF = 16;

   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int RANK_W   = 16;
   localparam int DEL_W    = 3;
   localparam int COUNT_W  = 4;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef struct packed {
      logic push;
      logic remove;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/spq_if.sv =====
interface spq_req_if;
   logic                                valid;
   logic                                ready;
   logic [spq_pkg::CMD_W-1:0]           cmd;
   logic signed [spq_pkg::VALUE_W-1:0]  item_value;
   logic [spq_pkg::RANK_W-1:0]          item_rank;
   logic [spq_pkg::DEL_W-1:0]           del_index;

   modport source (output valid, cmd, item_value, item_rank, del_index, input ready);
   modport sink   (input valid, cmd, item_value, item_rank, del_index, output ready);
endinterface

interface spq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [spq_pkg::VALUE_W-1:0]  out_value;
   logic [spq_pkg::RANK_W-1:0]          out_rank;
   logic                                out_valid;
   logic [spq_pkg::STATUS_W-1:0]        status;
   logic [spq_pkg::COUNT_W-1:0]         count;
   logic signed [spq_pkg::VALUE_W-1:0]  top_value;
   logic [spq_pkg::RANK_W-1:0]          top_rank;

   modport source (output valid, out_value, out_rank, out_valid, status, count,
                   top_value, top_rank, input ready);
   modport sink   (input valid, out_value, out_rank, out_valid, status, count,
                   top_value, top_rank, output ready);
endinterface

// ===== rtl/core/sorted_priority_queue_top.sv =====
// channel   | dir | handshake       | payload
// req_chan  | in  | valid / ready   | cmd, item_value, item_rank, del_index
// rsp_chan  | out | valid / ready   | out_value, out_rank, out_valid, status, count,
//           |     |                 | top_value, top_rank
//
// One request per cycle while req_chan.ready is high: the whole cell chain shifts in the accept cycle.
// Response appears registered in the cycle after the request is accepted.
// req_chan.ready drops only while a response is held and rsp_chan.ready is low.
// Synchronous reset empties the queue and drops the response; entries keep garbage.
`include "sorted_priority_queue_top_defines.svh"

module sorted_priority_queue_top #(
   parameter int DEPTH     = spq_pkg::DEPTH_DEF,
   parameter int RANK_BITS = spq_pkg::RANK_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   spq_req_if.sink      req_chan,
   spq_rsp_if.source    rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = (CNT_W > spq_pkg::DEL_W) ? CNT_W : spq_pkg::DEL_W;

   logic                               accept;
   logic [POS_W-1:0]                   pos;
   logic                               full;
   logic                               push_ok;
   logic                               rm_ok;
   spq_pkg::status_type                status_sel;
   spq_pkg::cell_ctrl_type             ctrl;
   logic [RANK_BITS-1:0]               new_rank;

   logic [CNT_W-1:0]                   count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [spq_pkg::VALUE_W-1:0] out_value_ff, out_value_in;
   logic [spq_pkg::RANK_W-1:0]         out_rank_ff, out_rank_in;
   logic                               out_valid_ff;
   spq_pkg::status_type                status_ff;

   logic signed [spq_pkg::VALUE_W-1:0] cell_value [DEPTH];
   logic [RANK_BITS-1:0]               cell_rank  [DEPTH];
   logic                               cell_ge    [DEPTH];
   logic signed [spq_pkg::VALUE_W-1:0] sel_value  [DEPTH];
   logic [RANK_BITS-1:0]               sel_rank   [DEPTH];
   logic signed [spq_pkg::VALUE_W-1:0] removed_value;
   logic [RANK_BITS-1:0]               removed_rank;

   logic                               head_ordered;
   logic                               rsp_consistent;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign new_rank       = RANK_BITS'(req_chan.item_rank);
   assign full           = count_ff == CNT_W'(DEPTH);

   always_comb begin
      if (req_chan.cmd == spq_pkg::CMD_POP) begin
         pos = '0;
      end else begin
         pos = POS_W'(req_chan.del_index);
      end
   end

   always_comb begin
      push_ok    = 1'b0;
      rm_ok      = 1'b0;
      status_sel = spq_pkg::ST_OK;
      case (spq_pkg::cmd_type'(req_chan.cmd))
         spq_pkg::CMD_PUSH: begin
            if (full) begin
               status_sel = spq_pkg::ST_FULL;
            end else begin
               push_ok = 1'b1;
            end
         end
         spq_pkg::CMD_POP, spq_pkg::CMD_DELETE: begin
            if (pos >= POS_W'(count_ff)) begin
               status_sel = spq_pkg::ST_BAD;
            end else begin
               rm_ok = 1'b1;
            end
         end
         default: begin
            status_sel = spq_pkg::ST_BAD;
         end
      endcase
   end

   assign ctrl.push   = accept && push_ok;
   assign ctrl.remove = accept && rm_ok;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                               left_ge;
         logic signed [spq_pkg::VALUE_W-1:0] left_value;
         logic [RANK_BITS-1:0]               left_rank;
         logic signed [spq_pkg::VALUE_W-1:0] right_value;
         logic [RANK_BITS-1:0]               right_rank;

         if (i == 0) begin : g_head
            assign left_ge    = 1'b1;
            assign left_value = req_chan.item_value;
            assign left_rank  = new_rank;
         end else begin : g_body
            assign left_ge    = cell_ge[i-1];
            assign left_value = cell_value[i-1];
            assign left_rank  = cell_rank[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign right_value = cell_value[i];
            assign right_rank  = cell_rank[i];
         end else begin : g_link
            assign right_value = cell_value[i+1];
            assign right_rank  = cell_rank[i+1];
         end

         spq_cell #(
            .IDX       (i),
            .CNT_W     (CNT_W),
            .POS_W     (POS_W),
            .RANK_BITS (RANK_BITS)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .count       (count_ff),
            .pos         (pos),
            .new_value   (req_chan.item_value),
            .new_rank    (new_rank),
            .left_ge     (left_ge),
            .left_value  (left_value),
            .left_rank   (left_rank),
            .right_value (right_value),
            .right_rank  (right_rank),
            .ge          (cell_ge[i]),
            .value       (cell_value[i]),
            .rank        (cell_rank[i]),
            .sel_value   (sel_value[i]),
            .sel_rank    (sel_rank[i])
         );
      end
   endgenerate

   always_comb begin
      removed_value = '0;
      removed_rank  = '0;
      for (int k = 0; k < DEPTH; k++) begin
         removed_value = removed_value | sel_value[k];
         removed_rank  = removed_rank | sel_rank[k];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign out_value_in = rm_ok ? removed_value : '0;
   assign out_rank_in  = rm_ok ? spq_pkg::RANK_W'(removed_rank) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_value_ff <= out_value_in;
         out_rank_ff  <= out_rank_in;
         out_valid_ff <= rm_ok;
         status_ff    <= status_sel;
      end
   end

   // queue state only moves on accept, so top and count track the held response
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_value = out_value_ff;
   assign rsp_chan.out_rank  = out_rank_ff;
   assign rsp_chan.out_valid = out_valid_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.count     = spq_pkg::COUNT_W'(count_ff);
   assign rsp_chan.top_value = (count_ff != '0) ? cell_value[0] : '0;
   assign rsp_chan.top_rank  = (count_ff != '0) ? spq_pkg::RANK_W'(cell_rank[0]) : '0;

   assign head_ordered   = (count_ff < CNT_W'(2)) || (cell_rank[0] >= cell_rank[1]);
   assign rsp_consistent = rsp_valid_ff && (!out_valid_ff || status_ff == spq_pkg::ST_OK);

   `SPQ_ASSERT(a_count_range, count_ff <= CNT_W'(DEPTH), "entry count exceeds depth")
   `SPQ_ASSERT(a_head_sorted, head_ordered, "top entries out of order")
   `SPQ_ASSERT_NEXT(a_count_hold, !accept, $stable(count_ff), "count moved without a request")
   `SPQ_ASSERT_NEXT(a_rsp_after_req, accept, rsp_consistent, "response missing or inconsistent")

endmodule

// ===== rtl/core/spq_cell.sv =====
module spq_cell #(
   parameter int IDX       = 0,
   parameter int CNT_W     = 4,
   parameter int POS_W     = 4,
   parameter int RANK_BITS = spq_pkg::RANK_BITS_DEF
) (
   input  logic                                clock,
   input  spq_pkg::cell_ctrl_type              ctrl,
   input  logic [CNT_W-1:0]                    count,
   input  logic [POS_W-1:0]                    pos,
   input  logic signed [spq_pkg::VALUE_W-1:0]  new_value,
   input  logic [RANK_BITS-1:0]                new_rank,
   input  logic                                left_ge,
   input  logic signed [spq_pkg::VALUE_W-1:0]  left_value,
   input  logic [RANK_BITS-1:0]                left_rank,
   input  logic signed [spq_pkg::VALUE_W-1:0]  right_value,
   input  logic [RANK_BITS-1:0]                right_rank,
   output logic                                ge,
   output logic signed [spq_pkg::VALUE_W-1:0]  value,
   output logic [RANK_BITS-1:0]                rank,
   output logic signed [spq_pkg::VALUE_W-1:0]  sel_value,
   output logic [RANK_BITS-1:0]                sel_rank
);

   localparam logic [CNT_W-1:0] CELL_CNT = CNT_W'(IDX);
   localparam logic [POS_W-1:0] CELL_POS = POS_W'(IDX);

   logic signed [spq_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [RANK_BITS-1:0]               rank_ff, rank_in;
   logic                               occupied;
   logic                               hit;

   assign occupied = CELL_CNT < count;
   assign ge       = occupied && (rank_ff >= new_rank);
   assign hit      = CELL_POS == pos;

   always_comb begin
      value_in = value_ff;
      rank_in  = rank_ff;
      if (ctrl.push && !ge) begin
         // insertion point takes the new entry, cells below it shift down
         if (left_ge) begin
            value_in = new_value;
            rank_in  = new_rank;
         end else begin
            value_in = left_value;
            rank_in  = left_rank;
         end
      end else if (ctrl.remove && (CELL_POS >= pos)) begin
         value_in = right_value;
         rank_in  = right_rank;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rank_ff  <= rank_in;
   end

   assign value     = value_ff;
   assign rank      = rank_ff;
   assign sel_value = hit ? value_ff : '0;
   assign sel_rank  = hit ? rank_ff : '0;

endmodule
